/* rtl/core/etl_pkg.sv */
package etl_pkg;

   // Width of the character position counter; offsets and lengths leave
   // the block as their low FieldBits bits.
   localparam int PosBits   = 16;
   localparam int FieldBits = 16;

   localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

   // Entries in the token output queue
   localparam int QDepth = 4;

   // Token kinds as carried on the result channel
   typedef enum logic [3:0] {
      TK_NUMBER   = 4'd0,
      TK_BAREWORD = 4'd1,
      TK_PLUS     = 4'd2,
      TK_MINUS    = 4'd3,
      TK_TIMES    = 4'd4,
      TK_DIVIDE   = 4'd5,
      TK_LPAREN   = 4'd6,
      TK_RPAREN   = 4'd7,
      TK_COMMA    = 4'd8,
      TK_LBRACKET = 4'd9,
      TK_RBRACKET = 4'd10,
      TK_STRING   = 4'd11,
      TK_COLCOL   = 4'd12,
      TK_END      = 4'd13,
      TK_BADCHAR  = 4'd14,
      TK_UNTERM   = 4'd15
   } kind_type;

   // Number unit suffixes
   typedef enum logic [2:0] {
      UNIT_NONE    = 3'd0,
      UNIT_SAMP    = 3'd1,
      UNIT_SEC     = 3'd2,
      UNIT_S       = 3'd3,
      UNIT_B       = 3'd4,
      UNIT_BEAT    = 3'd5,
      UNIT_PERCENT = 3'd6
   } unit_type;

   typedef struct packed {
      kind_type               kind;
      unit_type               unit;
      logic [FieldBits-1:0]   start;
      logic [FieldBits-1:0]   length;
   } tok_type;

   typedef struct packed {
      tok_type tok;
      logic    last;
   } entry_type;

   function automatic tok_type mk_tok(kind_type kind, unit_type unit,
                                      logic [FieldBits-1:0] start,
                                      logic [FieldBits-1:0] length);
      tok_type t;
      t.kind   = kind;
      t.unit   = unit;
      t.start  = start;
      t.length = length;
      return t;
   endfunction

endpackage

/* rtl/core/expression_token_lexer_unit.sv */
// Expression lexer: takes one ASCII character per req transfer (req_tlast marks
// end of text, with the data ignored) and returns tokens on rsp as kind, number
// unit, start offset and length; rsp_tlast flags the last token that one input
// character caused. Each character is lexed in the cycle it is taken, and its
// tokens go into a four-entry output queue that drains one token per cycle while
// rsp_tready is high. With rsp_tready high, characters are taken back to back,
// one per cycle, as long as each produces at most one token; a character that
// closes several tokens at once (a failed unit suffix followed by an operator,
// for example) holds req_tready low until the queue is down to one token, as it
// takes new input only while it holds at most one token. The end of text always
// yields an end token and resets the lexer state, position zero included.
module expression_token_lexer_unit (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_text
   // token output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] token_kind, [6:4] unit_code,
                                    // [22:7] token_start, [38:23] token_length
   output logic        rsp_tlast    // last_of_run
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_MINUS,
      MODE_NUMBER,
      MODE_SUFFIX,
      MODE_PLURAL,
      MODE_BAREWORD,
      MODE_STRING,
      MODE_COLON,
      MODE_ERROR
   } mode_type;

   // Character classes
   function automatic logic is_digit(logic [7:0] ch);
      return (ch >= "0") && (ch <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] ch);
      return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
   endfunction

   function automatic logic is_space(logic [7:0] ch);
      return (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
   endfunction

   // Suffix words: length and expected character at a given progress
   function automatic logic [2:0] sfx_len(etl_pkg::unit_type u);
      logic [2:0] n;
      unique case (u)
         etl_pkg::UNIT_SEC: n = 3'd3;
         default:           n = 3'd4;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] sfx_char(etl_pkg::unit_type u, logic [2:0] p);
      logic [7:0] sc;
      sc = 8'd0;
      unique case (u)
         etl_pkg::UNIT_SAMP: begin
            unique case (p)
               3'd0:    sc = "s";
               3'd1:    sc = "a";
               3'd2:    sc = "m";
               3'd3:    sc = "p";
               default: sc = 8'd0;
            endcase
         end
         etl_pkg::UNIT_SEC: begin
            unique case (p)
               3'd0:    sc = "s";
               3'd1:    sc = "e";
               3'd2:    sc = "c";
               default: sc = 8'd0;
            endcase
         end
         default: begin
            unique case (p)
               3'd0:    sc = "b";
               3'd1:    sc = "e";
               3'd2:    sc = "a";
               3'd3:    sc = "t";
               default: sc = 8'd0;
            endcase
         end
      endcase
      return sc;
   endfunction

   // Lexer state
   mode_type                     mode_ff, mode_in;
   logic [etl_pkg::PosBits-1:0]  pos_ff, pos_in;
   logic [etl_pkg::PosBits-1:0]  tb_ff, tb_in;
   logic [etl_pkg::PosBits-1:0]  sb_ff, sb_in;
   logic [2:0]                   prog_ff, prog_in;
   etl_pkg::unit_type            unit_ff, unit_in;
   logic                         esc_ff, esc_in;

   // Output queue, entry 0 is the head
   etl_pkg::entry_type           q_ff [etl_pkg::QDepth];
   etl_pkg::entry_type           q_in [etl_pkg::QDepth];
   logic [2:0]                   cnt_ff, cnt_in;

   // Tokens produced by the current character
   etl_pkg::tok_type             toks [3];
   logic [1:0]                   ntok;

   logic                         push, pop;
   logic [7:0]                   c;
   logic                         e;
   logic [etl_pkg::PosBits-1:0]  cur;
   logic [etl_pkg::PosBits-1:0]  d_cur_tb, d_sb_tb, d_cur_sb;
   logic                         bw_close;

   assign c   = req_tdata;
   assign e   = req_tlast;
   assign cur = pos_ff;

   assign d_cur_tb = cur - tb_ff;
   assign d_sb_tb  = sb_ff - tb_ff;
   assign d_cur_sb = cur - sb_ff;
   assign bw_close = e || !(is_digit(c) || is_alpha(c) || (c == "_"));

   assign req_tready = (cnt_ff <= 3'd1);
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {1'b0, q_ff[0].tok.length, q_ff[0].tok.start,
                        q_ff[0].tok.unit, q_ff[0].tok.kind};
   assign rsp_tlast  = q_ff[0].last;

   // Lexing of one character: next state and up to three tokens
   always_comb begin
      logic run_idle;
      logic fail;
      mode_in  = mode_ff;
      tb_in    = tb_ff;
      sb_in    = sb_ff;
      prog_in  = prog_ff;
      unit_in  = unit_ff;
      esc_in   = esc_ff;
      ntok     = 2'd0;
      run_idle = 1'b0;
      fail     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         toks[i] = '0;
      end

      unique case (mode_ff)
         MODE_MINUS: begin
            if (!e && (is_digit(c) || (c == "."))) begin
               mode_in = MODE_NUMBER;
            end else begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_MINUS, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'd1);
               ntok = ntok + 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (!e && (is_digit(c) || (c == ".") || (c == "e") || (c == "E"))) begin
               mode_in = MODE_NUMBER;
            end else if (!e && ((c == "s") || (c == "b"))) begin
               mode_in = MODE_SUFFIX;
               sb_in   = cur;
               prog_in = 3'd1;
               unit_in = (c == "s") ? etl_pkg::UNIT_S : etl_pkg::UNIT_B;
            end else if (!e && (c == "%")) begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_NUMBER, etl_pkg::UNIT_PERCENT,
                                            16'(tb_ff), 16'(d_cur_tb + 1'b1));
               ntok = ntok + 2'd1;
               mode_in = MODE_IDLE;
            end else begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_NUMBER, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'(d_cur_tb));
               ntok = ntok + 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_SUFFIX: begin
            if ((prog_ff == 3'd1) &&
                ((unit_ff == etl_pkg::UNIT_S) || (unit_ff == etl_pkg::UNIT_B))) begin
               // single letter so far: extend to a longer word, fail, or close
               if (!e && (unit_ff == etl_pkg::UNIT_S) && (c == "a")) begin
                  unit_in = etl_pkg::UNIT_SAMP;
                  prog_in = 3'd2;
               end else if (!e && (unit_ff == etl_pkg::UNIT_S) && (c == "e")) begin
                  unit_in = etl_pkg::UNIT_SEC;
                  prog_in = 3'd2;
               end else if (!e && (unit_ff == etl_pkg::UNIT_B) && (c == "e")) begin
                  unit_in = etl_pkg::UNIT_BEAT;
                  prog_in = 3'd2;
               end else if (!e && (is_digit(c) || is_alpha(c))) begin
                  fail = 1'b1;
               end else begin
                  toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_NUMBER, unit_ff,
                                               16'(tb_ff), 16'(d_sb_tb + 1'b1));
                  ntok = ntok + 2'd1;
                  prog_in = 3'd0;
                  unit_in = etl_pkg::UNIT_NONE;
                  run_idle = 1'b1;
               end
            end else if ((unit_ff == etl_pkg::UNIT_SAMP) || (unit_ff == etl_pkg::UNIT_SEC) ||
                         (unit_ff == etl_pkg::UNIT_BEAT)) begin
               if (e || (prog_ff >= sfx_len(unit_ff)) ||
                   (c != sfx_char(unit_ff, prog_ff))) begin
                  fail = 1'b1;
               end else if ((prog_ff + 3'd1) == sfx_len(unit_ff)) begin
                  toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_NUMBER, unit_ff,
                                               16'(tb_ff), 16'(d_cur_tb + 1'b1));
                  ntok = ntok + 2'd1;
                  prog_in = 3'd0;
                  unit_in = etl_pkg::UNIT_NONE;
                  mode_in = MODE_PLURAL;
               end else begin
                  prog_in = prog_ff + 3'd1;
               end
            end else begin
               fail = 1'b1;
            end
         end
         MODE_PLURAL: begin
            if (!e && (c == "s")) begin
               mode_in = MODE_IDLE;
            end else begin
               run_idle = 1'b1;
            end
         end
         MODE_BAREWORD: begin
            if (bw_close) begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_BAREWORD, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'(d_cur_tb));
               ntok = ntok + 2'd1;
               run_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (e) begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_UNTERM, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'(d_cur_tb));
               ntok = ntok + 2'd1;
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_END, etl_pkg::UNIT_NONE,
                                            16'(cur), 16'd0);
               ntok = ntok + 2'd1;
               mode_in = MODE_ERROR;
            end else if (esc_ff) begin
               esc_in = 1'b0;
            end else if (c == "\\") begin
               esc_in = 1'b1;
            end else if (c == "\"") begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_STRING, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'(d_cur_tb + 1'b1));
               ntok = ntok + 2'd1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_COLON: begin
            if (!e && (c == ":")) begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_COLCOL, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'd2);
               ntok = ntok + 2'd1;
               mode_in = MODE_IDLE;
            end else begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_BADCHAR, etl_pkg::UNIT_NONE,
                                            16'(tb_ff), 16'd1);
               ntok = ntok + 2'd1;
               mode_in = MODE_ERROR;
               if (e) begin
                  toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_END, etl_pkg::UNIT_NONE,
                                               16'(cur), 16'd0);
                  ntok = ntok + 2'd1;
               end
            end
         end
         MODE_ERROR: begin
            if (e) begin
               toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_END, etl_pkg::UNIT_NONE,
                                            16'(cur), 16'd0);
               ntok = ntok + 2'd1;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      // Failed suffix: close the number, buffered letters start a bareword
      if (fail) begin
         toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_NUMBER, etl_pkg::UNIT_NONE,
                                      16'(tb_ff), 16'(d_sb_tb));
         ntok = ntok + 2'd1;
         tb_in   = sb_ff;
         prog_in = 3'd0;
         unit_in = etl_pkg::UNIT_NONE;
         if (bw_close) begin
            toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_BAREWORD, etl_pkg::UNIT_NONE,
                                         16'(sb_ff), 16'(d_cur_sb));
            ntok = ntok + 2'd1;
            run_idle = 1'b1;
         end else begin
            mode_in = MODE_BAREWORD;
         end
      end

      // Character seen between tokens
      if (run_idle) begin
         mode_in = MODE_IDLE;
         if (e) begin
            toks[ntok] = etl_pkg::mk_tok(etl_pkg::TK_END, etl_pkg::UNIT_NONE,
                                         16'(cur), 16'd0);
            ntok = ntok + 2'd1;
         end else if (is_space(c)) begin
            mode_in = MODE_IDLE;
         end else if (is_digit(c) || (c == ".")) begin
            mode_in = MODE_NUMBER;
            tb_in   = cur;
         end else if (c == "-") begin
            mode_in = MODE_MINUS;
            tb_in   = cur;
         end else if (is_alpha(c)) begin
            mode_in = MODE_BAREWORD;
            tb_in   = cur;
         end else if (c == "\"") begin
            mode_in = MODE_STRING;
            tb_in   = cur;
            esc_in  = 1'b0;
         end else if (c == ":") begin
            mode_in = MODE_COLON;
            tb_in   = cur;
         end else begin
            toks[ntok].unit   = etl_pkg::UNIT_NONE;
            toks[ntok].start  = 16'(cur);
            toks[ntok].length = 16'd1;
            priority case (c)
               "+":     toks[ntok].kind = etl_pkg::TK_PLUS;
               "*":     toks[ntok].kind = etl_pkg::TK_TIMES;
               "/":     toks[ntok].kind = etl_pkg::TK_DIVIDE;
               "(":     toks[ntok].kind = etl_pkg::TK_LPAREN;
               ")":     toks[ntok].kind = etl_pkg::TK_RPAREN;
               ",":     toks[ntok].kind = etl_pkg::TK_COMMA;
               "[":     toks[ntok].kind = etl_pkg::TK_LBRACKET;
               "]":     toks[ntok].kind = etl_pkg::TK_RBRACKET;
               default: begin
                  toks[ntok].kind = etl_pkg::TK_BADCHAR;
                  mode_in = MODE_ERROR;
               end
            endcase
            ntok = ntok + 2'd1;
         end
      end
   end

   // Queue update: shift out the head, append this character's tokens
   always_comb begin
      logic [2:0] base;
      logic [2:0] slot;
      base = pop ? (cnt_ff - 3'd1) : cnt_ff;
      for (int i = 0; i < etl_pkg::QDepth; i++) begin
         if (pop && (i < etl_pkg::QDepth - 1)) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      for (int j = 0; j < 3; j++) begin
         slot = base + 3'(j);
         if (push && (3'(j) < {1'b0, ntok})) begin
            q_in[slot[1:0]].tok  = toks[j];
            q_in[slot[1:0]].last = (3'(j) == ({1'b0, ntok} - 3'd1));
         end
      end
      cnt_in = base + (push ? {1'b0, ntok} : 3'd0);
   end

   // Next character position, saturating
   assign pos_in = (pos_ff == etl_pkg::PosMax) ? pos_ff : (pos_ff + 1'b1);

   // State and queue registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < etl_pkg::QDepth; i++) begin
         q_ff[i] <= q_in[i];
      end
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         tb_ff   <= '0;
         sb_ff   <= '0;
         prog_ff <= 3'd0;
         unit_ff <= etl_pkg::UNIT_NONE;
         esc_ff  <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push && e) begin
            mode_ff <= MODE_IDLE;
            pos_ff  <= '0;
            tb_ff   <= '0;
            sb_ff   <= '0;
            prog_ff <= 3'd0;
            unit_ff <= etl_pkg::UNIT_NONE;
            esc_ff  <= 1'b0;
         end else if (push) begin
            mode_ff <= mode_in;
            pos_ff  <= pos_in;
            tb_ff   <= tb_in;
            sb_ff   <= sb_in;
            prog_ff <= prog_in;
            unit_ff <= unit_in;
            esc_ff  <= esc_in;
         end
      end
   end

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(etl_pkg::QDepth))
      else $error("token queue count out of range");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> (mode_ff == MODE_IDLE && pos_ff == '0))
      else $error("end of text did not return lexer to reset state");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> rsp_tvalid)
      else $error("end of text produced no token");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && cnt_ff >= 3'd2))
      else $error("input stalled without queued tokens");

endmodule

/* bench/expression_token_lexer_unit_test.sv */
`timescale 1ns / 100ps

module expression_token_lexer_unit_test;

   typedef logic [etl_pkg::PosBits-1:0] pos_type;

   // Scanner modes of the token predictor
   typedef enum int {
      LX_IDLE, LX_MINUS, LX_NUMBER, LX_SUFFIX, LX_PLURAL,
      LX_BAREWORD, LX_STRING, LX_COLON, LX_ERROR
   } scan_mode_type;

   // Token predictor plus the queue of tokens still owed by the block
   class lexer_scoreboard;
      scan_mode_type      mode;
      pos_type            position;
      pos_type            here;
      pos_type            tok_begin;
      pos_type            sfx_begin;
      int unsigned        sfx_index;
      etl_pkg::unit_type  sfx_unit;
      bit                 plural_ok;
      bit                 in_escape;
      etl_pkg::entry_type step_tokens[$];
      etl_pkg::entry_type owed_tokens[$];
      int                 mismatches;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         mode      = LX_IDLE;
         position  = '0;
         tok_begin = '0;
         sfx_begin = '0;
         sfx_index = 0;
         sfx_unit  = etl_pkg::UNIT_NONE;
         plural_ok = 1'b0;
         in_escape = 1'b0;
      endfunction

      function bit is_digit(logic [7:0] ch);
         return ch >= "0" && ch <= "9";
      endfunction

      function bit is_alpha(logic [7:0] ch);
         return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
      endfunction

      function bit is_alnum(logic [7:0] ch);
         return is_digit(ch) || is_alpha(ch);
      endfunction

      function bit is_space(logic [7:0] ch);
         return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
      endfunction

      function string unit_word(etl_pkg::unit_type u);
         case (u)
            etl_pkg::UNIT_SAMP: return "samp";
            etl_pkg::UNIT_SEC:  return "sec";
            etl_pkg::UNIT_BEAT: return "beat";
            default:            return "";
         endcase
      endfunction

      // at most three tokens per character
      function void emit(etl_pkg::kind_type kind, etl_pkg::unit_type unit,
                         pos_type start, pos_type length);
         etl_pkg::entry_type e;
         if (step_tokens.size() >= 3) return;
         e.tok.kind   = kind;
         e.tok.unit   = unit;
         e.tok.start  = start[etl_pkg::FieldBits-1:0];
         e.tok.length = length[etl_pkg::FieldBits-1:0];
         e.last       = 1'b0;
         step_tokens.push_back(e);
      endfunction

      function void idle_char(logic [7:0] ch, bit eot);
         mode = LX_IDLE;
         if (eot) begin
            emit(etl_pkg::TK_END, etl_pkg::UNIT_NONE, here, pos_type'(0));
            return;
         end
         if (is_space(ch)) return;
         if (is_digit(ch) || ch == ".") begin
            mode = LX_NUMBER;
            tok_begin = here;
         end else if (ch == "-") begin
            mode = LX_MINUS;
            tok_begin = here;
         end else if (is_alpha(ch)) begin
            mode = LX_BAREWORD;
            tok_begin = here;
         end else begin
            case (ch)
               "+": emit(etl_pkg::TK_PLUS, etl_pkg::UNIT_NONE, here, pos_type'(1));
               "*": emit(etl_pkg::TK_TIMES, etl_pkg::UNIT_NONE, here, pos_type'(1));
               "/": emit(etl_pkg::TK_DIVIDE, etl_pkg::UNIT_NONE, here, pos_type'(1));
               "(": emit(etl_pkg::TK_LPAREN, etl_pkg::UNIT_NONE, here, pos_type'(1));
               ")": emit(etl_pkg::TK_RPAREN, etl_pkg::UNIT_NONE, here, pos_type'(1));
               ",": emit(etl_pkg::TK_COMMA, etl_pkg::UNIT_NONE, here, pos_type'(1));
               "[": emit(etl_pkg::TK_LBRACKET, etl_pkg::UNIT_NONE, here, pos_type'(1));
               "]": emit(etl_pkg::TK_RBRACKET, etl_pkg::UNIT_NONE, here, pos_type'(1));
               "\"": begin
                  mode = LX_STRING;
                  tok_begin = here;
                  in_escape = 1'b0;
               end
               ":": begin
                  mode = LX_COLON;
                  tok_begin = here;
               end
               default: begin
                  emit(etl_pkg::TK_BADCHAR, etl_pkg::UNIT_NONE, here, pos_type'(1));
                  mode = LX_ERROR;
               end
            endcase
         end
      endfunction

      function void bareword_char(logic [7:0] ch, bit eot);
         if (!eot && (is_alnum(ch) || ch == "_")) return;
         emit(etl_pkg::TK_BAREWORD, etl_pkg::UNIT_NONE, tok_begin, here - tok_begin);
         idle_char(ch, eot);
      endfunction

      function void number_end(logic [7:0] ch, bit eot);
         if (!eot && (ch == "s" || ch == "b")) begin
            mode      = LX_SUFFIX;
            sfx_begin = here;
            sfx_index = 1;
            sfx_unit  = (ch == "s") ? etl_pkg::UNIT_S : etl_pkg::UNIT_B;
         end else if (!eot && ch == "%") begin
            emit(etl_pkg::TK_NUMBER, etl_pkg::UNIT_PERCENT, tok_begin,
                 here + pos_type'(1) - tok_begin);
            mode = LX_IDLE;
         end else begin
            emit(etl_pkg::TK_NUMBER, etl_pkg::UNIT_NONE, tok_begin, here - tok_begin);
            idle_char(ch, eot);
         end
      endfunction

      // failed suffix: number up to the suffix, letters restart as a bareword
      function void suffix_fail(logic [7:0] ch, bit eot);
         emit(etl_pkg::TK_NUMBER, etl_pkg::UNIT_NONE, tok_begin, sfx_begin - tok_begin);
         tok_begin = sfx_begin;
         mode      = LX_BAREWORD;
         sfx_index = 0;
         sfx_unit  = etl_pkg::UNIT_NONE;
         bareword_char(ch, eot);
      endfunction

      function void suffix_char(logic [7:0] ch, bit eot);
         string w;
         if (sfx_index == 1 &&
             (sfx_unit == etl_pkg::UNIT_S || sfx_unit == etl_pkg::UNIT_B)) begin
            if (!eot && sfx_unit == etl_pkg::UNIT_S && ch == "a") begin
               sfx_unit = etl_pkg::UNIT_SAMP;
               sfx_index = 2;
            end else if (!eot && sfx_unit == etl_pkg::UNIT_S && ch == "e") begin
               sfx_unit = etl_pkg::UNIT_SEC;
               sfx_index = 2;
            end else if (!eot && sfx_unit == etl_pkg::UNIT_B && ch == "e") begin
               sfx_unit = etl_pkg::UNIT_BEAT;
               sfx_index = 2;
            end else if (!eot && is_alnum(ch)) begin
               suffix_fail(ch, eot);
            end else begin
               // lone s or b closed by a non-alphanumeric or by end of text
               emit(etl_pkg::TK_NUMBER, sfx_unit, tok_begin,
                    sfx_begin + pos_type'(1) - tok_begin);
               sfx_index = 0;
               sfx_unit  = etl_pkg::UNIT_NONE;
               idle_char(ch, eot);
            end
            return;
         end
         w = unit_word(sfx_unit);
         if (eot || sfx_index >= w.len() || ch != w[sfx_index]) begin
            suffix_fail(ch, eot);
            return;
         end
         sfx_index++;
         if (sfx_index == w.len()) begin
            emit(etl_pkg::TK_NUMBER, sfx_unit, tok_begin, here + pos_type'(1) - tok_begin);
            sfx_index = 0;
            sfx_unit  = etl_pkg::UNIT_NONE;
            plural_ok = 1'b1;
            mode      = LX_PLURAL;
         end
      endfunction

      function void string_char(logic [7:0] ch, bit eot);
         if (eot) begin
            emit(etl_pkg::TK_UNTERM, etl_pkg::UNIT_NONE, tok_begin, here - tok_begin);
            mode = LX_ERROR;
            emit(etl_pkg::TK_END, etl_pkg::UNIT_NONE, here, pos_type'(0));
         end else if (in_escape) begin
            in_escape = 1'b0;
         end else if (ch == "\\") begin
            in_escape = 1'b1;
         end else if (ch == "\"") begin
            emit(etl_pkg::TK_STRING, etl_pkg::UNIT_NONE, tok_begin,
                 here + pos_type'(1) - tok_begin);
            mode = LX_IDLE;
         end
      endfunction

      // one accepted character (or end of text): queue the tokens it causes
      function void note_char(logic [7:0] ch, bit eot);
         step_tokens.delete();
         here = position;
         case (mode)
            LX_MINUS: begin
               if (!eot && (is_digit(ch) || ch == ".")) begin
                  mode = LX_NUMBER;
               end else begin
                  emit(etl_pkg::TK_MINUS, etl_pkg::UNIT_NONE, tok_begin, pos_type'(1));
                  idle_char(ch, eot);
               end
            end
            LX_NUMBER: begin
               if (eot || !(is_digit(ch) || ch == "." || ch == "e" || ch == "E"))
                  number_end(ch, eot);
            end
            LX_SUFFIX: suffix_char(ch, eot);
            LX_PLURAL: begin
               plural_ok = 1'b0;
               if (!eot && ch == "s") mode = LX_IDLE;
               else idle_char(ch, eot);
            end
            LX_BAREWORD: bareword_char(ch, eot);
            LX_STRING: string_char(ch, eot);
            LX_COLON: begin
               if (!eot && ch == ":") begin
                  emit(etl_pkg::TK_COLCOL, etl_pkg::UNIT_NONE, tok_begin, pos_type'(2));
                  mode = LX_IDLE;
               end else begin
                  emit(etl_pkg::TK_BADCHAR, etl_pkg::UNIT_NONE, tok_begin, pos_type'(1));
                  mode = LX_ERROR;
                  if (eot) emit(etl_pkg::TK_END, etl_pkg::UNIT_NONE, here, pos_type'(0));
               end
            end
            LX_ERROR: if (eot) emit(etl_pkg::TK_END, etl_pkg::UNIT_NONE, here, pos_type'(0));
            default: idle_char(ch, eot);
         endcase
         // position saturates; end of text returns the scanner state to reset
         if (eot) clear_state();
         else if (position != etl_pkg::PosMax) position++;
         if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
         foreach (step_tokens[i]) owed_tokens.push_back(step_tokens[i]);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // one token transfer against the oldest owed token
      function void check_token(logic [39:0] word, logic last_flag);
         etl_pkg::entry_type want;
         if (owed_tokens.size() == 0) begin
            $error("token with nothing owed: tdata %h tlast %b", word, last_flag);
            mismatches++;
            return;
         end
         want = owed_tokens.pop_front();
         compare_field("token_kind", 32'(want.tok.kind), 32'(word[3:0]));
         compare_field("unit_code", 32'(want.tok.unit), 32'(word[6:4]));
         compare_field("token_start", 32'(want.tok.start), 32'(word[22:7]));
         compare_field("token_length", 32'(want.tok.length), 32'(word[38:23]));
         compare_field("last_of_run", 32'(want.last), 32'(last_flag));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   lexer_scoreboard board;
   logic [7:0]      text_chars[$];
   int              burst_left = 0;
   int              rx_cycle = 0;
   int              rx_style = 0;

   string number_body = "0123456789.eE";
   string letters     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string word_tail   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   string op_chars    = "+-*/(),[]";
   string unit_tails[20] = '{"", "", "s", "b", "samp", "sec", "beat", "%", "samps",
                             "secs", "beats", "sa", "se", "be", "bea", "sam", "sx",
                             "b2", "beaty", "sec_"};

   expression_token_lexer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Monitor both channels at each edge; receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_token(rsp_tdata, rsp_tlast);
      end
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rx_cycle % 16) >= 10;
      endcase
   end

   // One character transfer, in bursts with random gaps
   task automatic send_char(input logic [7:0] ch, input bit eot);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Send the buffered text followed by its end of text mark
   task automatic send_text();
      foreach (text_chars[i]) send_char(text_chars[i], 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b1);
      text_chars.delete();
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
   endtask

   task automatic push_space();
      int pick;
      pick = $urandom_range(0, 5);
      text_chars.push_back(pick == 5 ? 8'd32 : 8'd9 + 8'(pick));
   endtask

   // One random lexical fragment, mostly well formed
   task automatic add_fragment();
      int pick;
      int n;
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
         if ($urandom_range(0, 3) == 0) text_chars.push_back("-");
         if ($urandom_range(0, 5) == 0) text_chars.push_back(".");
         else text_chars.push_back(8'd48 + 8'($urandom_range(0, 9)));
         n = $urandom_range(0, 3);
         repeat (n) text_chars.push_back(number_body[$urandom_range(0, 12)]);
         push_string(unit_tails[$urandom_range(0, 19)]);
      end else if (pick < 11) begin
         text_chars.push_back(letters[$urandom_range(0, 51)]);
         n = $urandom_range(0, 5);
         repeat (n) text_chars.push_back(word_tail[$urandom_range(0, 62)]);
      end else if (pick < 14) begin
         n = $urandom_range(0, 9);
         if (n == 9) begin
            if ($urandom_range(0, 3) == 0) push_string(":");
            else push_string("::");
         end else begin
            text_chars.push_back(op_chars[n]);
         end
      end else if (pick < 17) begin
         text_chars.push_back("\"");
         n = $urandom_range(0, 5);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) text_chars.push_back("\\");
            text_chars.push_back(8'($urandom_range(32, 126)));
         end
         if ($urandom_range(0, 7) != 0) text_chars.push_back("\"");
      end else if (pick < 19) begin
         push_space();
      end else begin
         text_chars.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) push_space();
   endtask

   // Stimulus
   initial begin
      int sent;
      int frags;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // plural swallowed, lone s unit closed by end of text
      push_string("-7samps+2s");
      send_text();
      // lone b, beat, rbracket, divide, comma, rparen
      push_string("1b*3beat]/,)");
      send_text();
      // failed suffix then operator: three tokens from one character
      push_string("5sa(");
      send_text();
      // percent, double colon, unterminated string with an escape
      push_string("9%::\"\\\"x");
      send_text();
      // pending minus, lone colon, ignored input after the error
      push_string("-x:q[");
      send_text();
      // codes outside printable range
      text_chars.push_back(8'hFF);
      send_text();
      text_chars.push_back(8'h00);
      push_string("1");
      send_text();

      // random texts of several fragments each
      sent = 0;
      while (sent < 110) begin
         frags = $urandom_range(2, 8);
         repeat (frags) add_fragment();
         sent += text_chars.size() + 1;
         send_text();
      end
      req_tvalid <= 1'b0;

      while (board.owed_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.owed_tokens.size() == 0) begin
         $display("expression_token_lexer_unit_test: PASS");
      end else begin
         $display("expression_token_lexer_unit_test: FAIL");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #4000000;
      $display("expression_token_lexer_unit_test: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/etl_pkg.sv
rtl/core/expression_token_lexer_unit.sv
bench/expression_token_lexer_unit_test.sv
